FILE: src/lpc_to_cepstrum_unit_assert.svh
// Assertion helpers for the LPC to cepstrum unit.
// They expect signals named clk and arst_n in the scope where they are used.
`ifndef LPC_TO_CEPSTRUM_UNIT_ASSERT_SVH
`define LPC_TO_CEPSTRUM_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/lpc_cep_pkg.sv
package lpc_cep_pkg;
	localparam int FRAC_BITS = 16;
	localparam int LOG_BITS = 20;
	localparam int CNT_W = 7;
	localparam int IDX_W = 6;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
endpackage

FILE: src/lpc_to_cepstrum_unit.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_ready      coef, last
// out       output     out_valid / out_ready    cep, cep_index, last_res, log_error
// cfg       input      cfg_valid / cfg_ready    cfg_data (out_count)
//
// Coefficients load at one per cycle while in_ready is high; the item with last set closes the frame.
// The logarithm of the gain term is found by normalizing, then 20 square steps.
// Each cm then takes one memory read pair per term through a three stage multiply
// pipeline, then a bit-serial divide by m into a 47-bit quotient.
// Each result is read, captured, then held until out_ready is seen; no new frame is
// accepted until the last result is taken. Reset clears control state only.
`include "lpc_to_cepstrum_unit_assert.svh"

module lpc_to_cepstrum_unit import lpc_cep_pkg::*; #(
	parameter int MAX_COEFFS = 64,
	parameter int COEF_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COEF_WIDTH-1:0] coef,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COEF_WIDTH-1:0] cep,
	output logic [IDX_W-1:0]      cep_index,
	output logic                  last_res,
	output logic                  log_error,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CNT_W-1:0]      cfg_data
);
	localparam int AW = $clog2(MAX_COEFFS);
	localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_COEFFS);
	localparam int PW = 2 * COEF_WIDTH;
	localparam longint SAT_HI = (longint'(1) <<< (COEF_WIDTH - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;
	localparam logic signed [71:0] ACC_LIM = 72'sd1 <<< 62;

	typedef enum logic [3:0] {
		S_LOAD, S_LOG, S_LOG_WAIT, S_MSTART, S_MAC, S_DIV_INIT, S_DIV, S_FIN,
		S_OUT_RD, S_OUT_CAP, S_OUT_HOLD
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q, n_q, size_q, m_q, k_q, kend_q, out_idx_q;
	logic [CNT_W-1:0] out_count_q;
	logic [COEF_WIDTH-1:0] a0_q;
	logic err_q;
	logic out_valid_q, last_res_q;
	logic [COEF_WIDTH-1:0] cep_q;
	logic [IDX_W-1:0] cep_index_q;

	// Memories
	logic [COEF_WIDTH-1:0] coef_mem [MAX_COEFFS];
	logic [COEF_WIDTH-1:0] cep_mem [MAX_COEFFS];
	logic [COEF_WIDTH-1:0] coef_rdata, cep_rdata;
	logic [AW-1:0] coef_raddr, cep_raddr, cep_waddr;
	logic [COEF_WIDTH-1:0] cep_wdata;
	logic cep_we, coef_we;

	// Multiply pipeline
	logic v_s1, v_s2, v_s3;
	logic [CNT_W-1:0] w_s1, w_s2;
	logic signed [PW-1:0] p_s2;
	logic signed [63:0] t_s3;
	logic signed [63:0] acc_q;

	// Divider
	logic neg_q;
	logic [46:0] num_q;
	logic [6:0] rem_q;
	logic [5:0] dcnt_q;

	logic in_acc, issue, log_start, log_done;
	logic [COEF_WIDTH-1:0] log_result;
	logic [CNT_W-1:0] n_next, w_now, m_diff;
	logic [CNT_W:0] size_raw;
	logic signed [71:0] scaled;
	logic signed [64:0] acc_sum;
	logic [63:0] acc_mag;
	logic [63:0] mag_rnd;
	logic [7:0] rem_n;
	logic signed [48:0] q_val;
	logic [COEF_WIDTH-1:0] fin_val;

	assign in_ready = (state_q == S_LOAD);
	assign in_acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign issue = (state_q == S_MAC) && (k_q < kend_q);
	assign log_start = (state_q == S_LOG) && !a0_q[COEF_WIDTH-1] && (a0_q != '0);

	always_comb begin
		n_next = cnt_q + ((cnt_q < MAXC) ? CNT_W'(1) : CNT_W'(0));
		if (out_count_q == '0) begin
			size_raw = {1'b0, n_next} + (CNT_W + 1)'(1);
		end else begin
			size_raw = {1'b0, out_count_q};
		end
		if (size_raw < (CNT_W + 1)'(2)) begin
			size_raw = (CNT_W + 1)'(2);
		end
		if (size_raw > {1'b0, MAXC}) begin
			size_raw = {1'b0, MAXC};
		end

		m_diff = m_q - k_q;
		w_now = m_diff;
		coef_we = in_acc && (cnt_q < MAXC);
		coef_raddr = (state_q == S_MAC) ? k_q[AW-1:0] : m_q[AW-1:0];
		cep_raddr = (state_q == S_MAC) ? m_diff[AW-1:0] : out_idx_q[AW-1:0];

		// A weighted term saturates at +-2^62, and so does the running sum.
		scaled = 72'(p_s2) * $signed({1'b0, 8'(w_s2)});
		acc_sum = 65'(acc_q) + 65'(t_s3);
		acc_mag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
		mag_rnd = acc_mag + {43'd0, m_q[5:0], 15'd0};
		rem_n = {rem_q, num_q[46]};

		// cm is the negated rounded quotient, less a[m] while m is below the loaded count.
		q_val = neg_q ? $signed({2'b00, num_q}) : -$signed({2'b00, num_q});
		if (m_q < n_q) begin
			q_val = q_val - 49'($signed(coef_rdata));
		end
		if (q_val > SAT_HI) begin
			fin_val = COEF_WIDTH'(SAT_HI);
		end else if (q_val < SAT_LO) begin
			fin_val = COEF_WIDTH'(SAT_LO);
		end else begin
			fin_val = COEF_WIDTH'(q_val);
		end

		cep_we = 1'b0;
		cep_waddr = m_q[AW-1:0];
		cep_wdata = fin_val;
		if (state_q == S_LOG && !log_start) begin
			cep_we = 1'b1;
			cep_waddr = '0;
			cep_wdata = '0;
		end else if (state_q == S_LOG_WAIT && log_done) begin
			cep_we = 1'b1;
			cep_waddr = '0;
			cep_wdata = log_result;
		end else if (state_q == S_FIN) begin
			cep_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[cnt_q[AW-1:0]] <= coef;
		end
		coef_rdata <= coef_mem[coef_raddr];
	end

	always_ff @(posedge clk) begin
		if (cep_we) begin
			cep_mem[cep_waddr] <= cep_wdata;
		end
		cep_rdata <= cep_mem[cep_raddr];
	end

	lpc_cep_log #(.COEF_WIDTH(COEF_WIDTH)) u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (a0_q),
		.done   (log_done),
		.result (log_result)
	);

	// Datapath registers
	always_ff @(posedge clk) begin
		w_s1 <= w_now;
		p_s2 <= PW'($signed(coef_rdata)) * PW'($signed(cep_rdata));
		w_s2 <= w_s1;
		if (scaled > ACC_LIM) begin
			t_s3 <= 64'(ACC_LIM);
		end else if (scaled < -ACC_LIM) begin
			t_s3 <= 64'(-ACC_LIM);
		end else begin
			t_s3 <= 64'(scaled);
		end
		if (state_q == S_MSTART) begin
			acc_q <= '0;
		end else if (v_s3) begin
			if (acc_sum > 65'(ACC_LIM)) begin
				acc_q <= 64'(ACC_LIM);
			end else if (acc_sum < -65'(ACC_LIM)) begin
				acc_q <= 64'(-ACC_LIM);
			end else begin
				acc_q <= 64'(acc_sum);
			end
		end
		if (in_acc && cnt_q == '0) begin
			a0_q <= coef;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q <= '0;
			out_count_q <= '0;
			out_valid_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				out_count_q <= cfg_data;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (last) begin
							n_q <= n_next;
							size_q <= size_raw[CNT_W-1:0];
							cnt_q <= '0;
							state_q <= S_LOG;
						end else begin
							cnt_q <= n_next;
						end
					end
				end
				S_LOG: begin
					err_q <= !log_start;
					m_q <= CNT_W'(1);
					state_q <= log_start ? S_LOG_WAIT : S_MSTART;
				end
				S_LOG_WAIT: begin
					if (log_done) begin
						state_q <= S_MSTART;
					end
				end
				S_MSTART: begin
					k_q <= CNT_W'(1);
					kend_q <= (m_q < n_q) ? m_q : n_q;
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (issue) begin
						k_q <= k_q + CNT_W'(1);
					end else if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_DIV_INIT;
					end
				end
				S_DIV_INIT: begin
					neg_q <= acc_q[63];
					num_q <= mag_rnd[62:16];
					rem_q <= '0;
					dcnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (rem_n >= {1'b0, m_q}) begin
						rem_q <= 7'(rem_n - {1'b0, m_q});
						num_q <= {num_q[45:0], 1'b1};
					end else begin
						rem_q <= rem_n[6:0];
						num_q <= {num_q[45:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd46) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					m_q <= m_q + CNT_W'(1);
					if (m_q + CNT_W'(1) == size_q) begin
						out_idx_q <= '0;
						state_q <= S_OUT_RD;
					end else begin
						state_q <= S_MSTART;
					end
				end
				S_OUT_RD: begin
					state_q <= S_OUT_CAP;
				end
				S_OUT_CAP: begin
					cep_q <= cep_rdata;
					cep_index_q <= out_idx_q[IDX_W-1:0];
					last_res_q <= (out_idx_q + CNT_W'(1) == size_q);
					out_valid_q <= 1'b1;
					state_q <= S_OUT_HOLD;
				end
				S_OUT_HOLD: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						out_idx_q <= out_idx_q + CNT_W'(1);
						state_q <= last_res_q ? S_LOAD : S_OUT_RD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign cep = cep_q;
	assign cep_index = cep_index_q;
	assign last_res = last_res_q;
	assign log_error = err_q;

	`LCU_ASSERT_SAME(a_no_overlap, in_ready, !out_valid, "input taken while a result is pending")
	`LCU_ASSERT_NEXT(a_frame_done, out_valid && out_ready && last_res, in_ready,
		"block did not return to loading after the final result")
	`LCU_ASSERT_SAME(a_mac_bound, state_q == S_MAC, k_q <= kend_q, "term index ran past its end")
	`LCU_ASSERT_SAME(a_last_index, out_valid && last_res,
		cep_index == IDX_W'(size_q - CNT_W'(1)), "final result index mismatch")
endmodule

FILE: src/lpc_cep_log.sv
module lpc_cep_log import lpc_cep_pkg::*; #(
	parameter int COEF_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COEF_WIDTH-1:0] x,
	output logic                  done,
	output logic [COEF_WIDTH-1:0] result
);
	typedef enum logic [2:0] {
		L_IDLE, L_NORM, L_SQ_MUL, L_SQ_ADJ, L_SCALE, L_ROUND
	} log_state_t;

	localparam longint SAT_HI = (longint'(1) <<< (COEF_WIDTH - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	log_state_t state_q;
	logic [30:0] mant_q;
	logic [4:0] e_q;
	logic [LOG_BITS-1:0] frac_q;
	logic [4:0] cnt_q;
	logic [61:0] sq_q;
	logic [56:0] sc_q;
	logic neg_q;
	logic done_q;
	logic [COEF_WIDTH-1:0] result_q;

	logic [31:0] sq_top;
	logic [5:0] exp_unb;
	logic [25:0] l2;
	logic [24:0] l2_mag;
	logic [57:0] rnd_sum;
	logic [21:0] r_mag;
	logic signed [22:0] r_val;

	always_comb begin
		sq_top = sq_q[61:30];
		// Unbiased exponent (e - 16) in front of the fraction bits gives log2 in Q.20.
		exp_unb = 6'({1'b0, e_q}) - 6'd16;
		l2 = {exp_unb, frac_q};
		l2_mag = l2[25] ? 25'(-l2) : l2[24:0];
		rnd_sum = {1'b0, sc_q} + (58'd1 << 35);
		r_mag = rnd_sum[57:36];
		r_val = neg_q ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == L_ROUND);
			case (state_q)
				L_IDLE: begin
					if (start) begin
						mant_q <= 31'(x[COEF_WIDTH-2:0]);
						e_q <= 5'd30;
						cnt_q <= '0;
						frac_q <= '0;
						state_q <= L_NORM;
					end
				end
				L_NORM: begin
					// Shift the leading one up to bit 30, one place a cycle.
					if (mant_q[30]) begin
						state_q <= L_SQ_MUL;
					end else begin
						mant_q <= {mant_q[29:0], 1'b0};
						e_q <= e_q - 5'd1;
					end
				end
				L_SQ_MUL: begin
					sq_q <= 62'(mant_q) * 62'(mant_q);
					state_q <= L_SQ_ADJ;
				end
				L_SQ_ADJ: begin
					if (sq_top[31]) begin
						mant_q <= sq_top[31:1];
						frac_q <= {frac_q[LOG_BITS-2:0], 1'b1};
					end else begin
						mant_q <= sq_top[30:0];
						frac_q <= {frac_q[LOG_BITS-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					state_q <= (cnt_q == 5'(LOG_BITS - 1)) ? L_SCALE : L_SQ_MUL;
				end
				L_SCALE: begin
					neg_q <= l2[25];
					sc_q <= 57'(l2_mag) * 57'(LN2_Q32);
					state_q <= L_ROUND;
				end
				L_ROUND: begin
					if (r_val > SAT_HI) begin
						result_q <= COEF_WIDTH'(SAT_HI);
					end else if (r_val < SAT_LO) begin
						result_q <= COEF_WIDTH'(SAT_LO);
					end else begin
						result_q <= COEF_WIDTH'(r_val);
					end
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign result = result_q;
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import lpc_cep_pkg::*;

	localparam int MAXC = 64;
	localparam int CW = 24;
	localparam longint ACC_LIM = 64'sd1 <<< 62;
	localparam longint FIELD_HI = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint FIELD_LO = -(64'sd1 <<< (CW - 1));

	typedef struct {
		logic [CW-1:0]    cep;
		logic [IDX_W-1:0] idx;
		logic             lst;
		logic             err;
	} cep_result_t;

	class cepstrum_scoreboard;
		longint coef_mem[MAXC];
		longint cep_mem[MAXC];
		int unsigned n_loaded;
		int unsigned out_cnt;
		cep_result_t pending[$];
		int errors;

		function new();
			n_loaded = 0;
			out_cnt = 0;
			errors = 0;
		endfunction

		function automatic longint clamp_field(longint v);
			if (v > FIELD_HI) return FIELD_HI;
			if (v < FIELD_LO) return FIELD_LO;
			return v;
		endfunction

		function automatic longint acc_add(longint a, longint b);
			if (b > 0 && a > ACC_LIM - b) return ACC_LIM;
			if (b < 0 && a < -ACC_LIM - b) return -ACC_LIM;
			return a + b;
		endfunction

		function automatic longint weight(longint p, longint w);
			if (p > ACC_LIM / w) return ACC_LIM;
			if (p < -(ACC_LIM / w)) return -ACC_LIM;
			return p * w;
		endfunction

		function automatic longint round_div(longint num, longint den);
			longint unsigned mag, q;
			mag = (num < 0) ? -num : num;
			q = (mag + den / 2) / den;
			return (num < 0) ? -longint'(q) : longint'(q);
		endfunction

		// Natural log of a positive Q.16 value by repeated squaring of the mantissa.
		function automatic longint ln_q16(longint unsigned x);
			int unsigned e;
			longint unsigned mant, mag, r;
			longint frac, l2;
			e = 0;
			frac = 0;
			while (e < 62 && (x >> (e + 1)) != 0) e++;
			mant = x << (30 - e);
			for (int i = 0; i < LOG_BITS; i++) begin
				mant = (mant * mant) >> 30;
				frac = frac << 1;
				if (mant >= (64'd1 << 31)) begin
					mant = mant >> 1;
					frac = frac | 1;
				end
			end
			l2 = (longint'(e) - FRAC_BITS) * (64'sd1 <<< LOG_BITS) + frac;
			mag = (l2 < 0) ? -l2 : l2;
			r = (mag * longint'(LN2_Q32) + (64'd1 << 35)) >> 36;
			return (l2 < 0) ? -longint'(r) : longint'(r);
		endfunction

		function void note_input(logic [CW-1:0] c, logic lst);
			int unsigned n, size, kend;
			longint acc, q;
			bit bad;
			cep_result_t r;
			if (n_loaded < MAXC) begin
				coef_mem[n_loaded] = longint'($signed(c));
				n_loaded++;
			end
			if (!lst) return;
			n = n_loaded;
			n_loaded = 0;
			size = (out_cnt == 0) ? n + 1 : out_cnt;
			if (size < 2) size = 2;
			if (size > MAXC) size = MAXC;
			bad = coef_mem[0] <= 0;
			cep_mem[0] = bad ? 0 : clamp_field(ln_q16(coef_mem[0]));
			for (int unsigned m = 1; m < size; m++) begin
				acc = 0;
				kend = (m < n) ? m : n;
				for (int unsigned k = 1; k < kend; k++)
					acc = acc_add(acc, weight(coef_mem[k] * cep_mem[m-k], m - k));
				q = -round_div(acc, longint'(m) << FRAC_BITS);
				if (m < n) q = q - coef_mem[m];
				cep_mem[m] = clamp_field(q);
			end
			for (int unsigned m = 0; m < size; m++) begin
				r.cep = cep_mem[m][CW-1:0];
				r.idx = m[IDX_W-1:0];
				r.lst = (m == size - 1);
				r.err = bad;
				pending.push_back(r);
			end
		endfunction

		function void check(logic [CW-1:0] c, logic [IDX_W-1:0] i, logic l, logic e);
			cep_result_t x;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result cep=%h index=%0d", $time, c, i);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (c !== x.cep) begin
				$display("%0t: cep[%0d] expected %h actual %h", $time, x.idx, x.cep, c);
				errors++;
			end
			if (i !== x.idx) begin
				$display("%0t: cep_index expected %0d actual %0d", $time, x.idx, i);
				errors++;
			end
			if (l !== x.lst) begin
				$display("%0t: last_res at %0d expected %b actual %b", $time, x.idx, x.lst, l);
				errors++;
			end
			if (e !== x.err) begin
				$display("%0t: log_error at %0d expected %b actual %b", $time, x.idx, x.err, e);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [CW-1:0] coef = '0;
	logic last = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [CW-1:0] cep;
	logic [IDX_W-1:0] cep_index;
	logic last_res;
	logic log_error;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	cepstrum_scoreboard sb = new();
	bit long_hold = 0;
	int burst_left = 0;

	lpc_to_cepstrum_unit #(.MAX_COEFFS(MAXC), .COEF_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .coef(coef), .last(last),
		.out_valid(out_valid), .out_ready(out_ready), .cep(cep), .cep_index(cep_index),
		.last_res(last_res), .log_error(log_error),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_input(coef, last);
		if (arst_n && out_valid && out_ready) sb.check(cep, cep_index, last_res, log_error);
	end

	// Receiver: alternates between free-running, stalling and random stretches, plus one long hold.
	initial begin
		int mode, span;
		forever begin
			if (long_hold) begin
				out_ready <= 0;
				repeat (3000) @(negedge clk);
				long_hold = 0;
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(1, 40);
			repeat (span) begin
				@(negedge clk);
				out_ready <= (mode == 0) ? 1'b1 : (mode == 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
			end
		end
	end

	task automatic send_item(logic [CW-1:0] c, logic l);
		if (burst_left == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1;
		coef <= c;
		last <= l;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_out_count(logic [CNT_W-1:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.out_cnt = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// One frame: gain term, then len-1 coefficients; wide selects full-range values.
	task automatic send_frame(int len, logic [CW-1:0] gain, bit wide);
		logic [CW-1:0] c;
		send_item(gain, len == 1);
		for (int i = 1; i < len; i++) begin
			c = wide ? CW'($urandom) : CW'($signed($urandom_range(0, 131072)) - 65536);
			send_item(c, i == len - 1);
		end
	endtask

	function automatic logic [CW-1:0] rand_gain();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return CW'($urandom);
		if (p == 1) return '0;
		return CW'($urandom_range(1, 24'h7FFFFF));
	endfunction

	task automatic random_frames(int items);
		int len, sent, p;
		sent = 0;
		while (sent < items) begin
			p = $urandom_range(0, 19);
			len = (p == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			send_frame(len, rand_gain(), $urandom_range(0, 4) == 0);
			sent += len;
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: gain extremes, nonpositive gain, coefficient extremes, long frames, output count settings.
		send_frame(1, 24'h010000, 0);
		send_frame(2, 24'h7FFFFF, 0);
		send_frame(2, 24'h000001, 0);
		send_frame(1, 24'h000000, 0);
		send_frame(1, 24'h800000, 0);
		send_item(24'h020000, 0);
		send_item(24'h7FFFFF, 0);
		send_item(24'h800000, 0);
		send_item(24'hFFFFFF, 1);
		send_frame(3, 24'hFFFFFF, 1);
		write_out_count(7'd1);
		send_frame(1, 24'h010000, 0);
		write_out_count(7'd64);
		send_frame(10, 24'h008000, 0);
		write_out_count(7'd127);
		send_frame(70, 24'h030000, 1);

		write_out_count(7'd0);
		random_frames(16);
		// Long receiver hold while frames keep coming.
		long_hold = 1;
		send_frame(8, 24'h010000, 0);
		send_frame(5, 24'h020000, 0);
		drain();
		write_out_count(7'd5);
		random_frames(12);
		write_out_count(7'd2);
		random_frames(10);
		write_out_count(7'd64);
		random_frames(10);
		write_out_count(7'd0);
		random_frames(10);

		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (sb.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#30ms;
		$display("tb: done, errors");
		$finish;
	end
endmodule

FILE: lpc_to_cepstrum_unit.f
+incdir+src
src/lpc_cep_pkg.sv
src/lpc_cep_log.sv
src/lpc_to_cepstrum_unit.sv
tb/tb.sv
